FILE: rtl/trs_pkg.sv
// Shared types and constants for the transform matrix builder.
`timescale 1ns / 1ps
package trs_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROT_N         = 9;
  localparam int PROD_W        = 64;
  localparam int NORM_W        = 65;
  localparam int NUM_W         = 66;
  localparam int ACC_W         = 66;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] move_x;
    logic signed [DATA_W-1:0] move_y;
    logic signed [DATA_W-1:0] move_z;
    logic signed [DATA_W-1:0] scale_x;
    logic signed [DATA_W-1:0] scale_y;
    logic signed [DATA_W-1:0] scale_z;
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
  } trs_in_t;

  typedef struct packed {
    logic [1:0]               row_index;
    logic signed [DATA_W-1:0] elem_c0;
    logic signed [DATA_W-1:0] elem_c1;
    logic signed [DATA_W-1:0] elem_c2;
    logic signed [DATA_W-1:0] elem_c3;
    logic                     final_row;
    logic                     degenerate;
  } trs_out_t;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] move_x;
    logic signed [DATA_W-1:0] move_y;
    logic signed [DATA_W-1:0] move_z;
    logic signed [DATA_W-1:0] scale_x;
    logic signed [DATA_W-1:0] scale_y;
    logic signed [DATA_W-1:0] scale_z;
    logic                     degen;
  } trs_side_t;

endpackage

FILE: rtl/trs_front.sv
// Quaternion products, norm, numerators and dividends for the rotation entries.
`timescale 1ns / 1ps
module trs_front #(
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_v,
  input  trs_pkg::trs_in_t                  item,
  output logic                              v,
  output logic [trs_pkg::NORM_W+FRAC_BITS:0] dvd [trs_pkg::ROT_N],
  output logic [trs_pkg::ROT_N-1:0]         neg,
  output logic [trs_pkg::NORM_W-1:0]        norm,
  output trs_pkg::trs_side_t                side
);

  localparam int DW = trs_pkg::NORM_W + FRAC_BITS + 1;
  localparam int PW = trs_pkg::PROD_W;
  localparam int NW = trs_pkg::NUM_W;

  logic                       v1, v2;
  trs_pkg::trs_side_t         side1, side2;
  trs_pkg::trs_side_t         side_next;
  logic signed [PW-1:0]       sq_w, sq_x, sq_y, sq_z;
  logic signed [PW-1:0]       pr_xy, pr_zw, pr_xz, pr_yw, pr_yz, pr_xw;
  logic [trs_pkg::NORM_W-1:0] norm2;
  logic signed [NW-1:0]       num2 [trs_pkg::ROT_N];
  logic signed [NW-1:0]       num_next [trs_pkg::ROT_N];
  logic [trs_pkg::NORM_W-1:0] norm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v  <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      v  <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_w  <= item.quat_w * item.quat_w;
      sq_x  <= item.quat_x * item.quat_x;
      sq_y  <= item.quat_y * item.quat_y;
      sq_z  <= item.quat_z * item.quat_z;
      pr_xy <= item.quat_x * item.quat_y;
      pr_zw <= item.quat_z * item.quat_w;
      pr_xz <= item.quat_x * item.quat_z;
      pr_yw <= item.quat_y * item.quat_w;
      pr_yz <= item.quat_y * item.quat_z;
      pr_xw <= item.quat_x * item.quat_w;
      side1 <= '{op: item.op, move_x: item.move_x, move_y: item.move_y,
                 move_z: item.move_z, scale_x: item.scale_x, scale_y: item.scale_y,
                 scale_z: item.scale_z, degen: 1'b0};
    end
  end

  always_comb begin
    norm_next   = trs_pkg::NORM_W'(sq_w) + trs_pkg::NORM_W'(sq_x)
                + trs_pkg::NORM_W'(sq_y) + trs_pkg::NORM_W'(sq_z);
    num_next[0] = NW'(sq_x) + NW'(sq_w) - NW'(sq_y) - NW'(sq_z);
    num_next[1] = (NW'(pr_xy) - NW'(pr_zw)) <<< 1;
    num_next[2] = (NW'(pr_xz) + NW'(pr_yw)) <<< 1;
    num_next[3] = (NW'(pr_xy) + NW'(pr_zw)) <<< 1;
    num_next[4] = NW'(sq_y) + NW'(sq_w) - NW'(sq_x) - NW'(sq_z);
    num_next[5] = (NW'(pr_yz) - NW'(pr_xw)) <<< 1;
    num_next[6] = (NW'(pr_xz) - NW'(pr_yw)) <<< 1;
    num_next[7] = (NW'(pr_yz) + NW'(pr_xw)) <<< 1;
    num_next[8] = NW'(sq_z) + NW'(sq_w) - NW'(sq_x) - NW'(sq_y);
    side_next       = side1;
    side_next.degen = (norm_next == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm2 <= norm_next;
      num2  <= num_next;
      side2 <= side_next;
    end
  end

  for (genvar e = 0; e < trs_pkg::ROT_N; e++) begin : g_dvd
    logic [NW-1:0] mag;
    assign mag = num2[e][NW-1] ? NW'(-num2[e]) : NW'(num2[e]);
    always_ff @(posedge clk) begin
      if (en) begin
        dvd[e] <= (DW'(mag[trs_pkg::NORM_W-1:0]) << FRAC_BITS) + DW'(norm2 >> 1);
        neg[e] <= num2[e][NW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm <= norm2;
      side <= side2;
    end
  end

endmodule

FILE: rtl/trs_div.sv
// Pipelined restoring divider, one quotient bit per stage, nine lanes sharing a divisor.
`timescale 1ns / 1ps
module trs_div #(
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_v,
  input  logic [trs_pkg::NORM_W+FRAC_BITS:0] dvd [trs_pkg::ROT_N],
  input  logic [trs_pkg::ROT_N-1:0]          neg,
  input  logic [trs_pkg::NORM_W-1:0]         norm,
  input  trs_pkg::trs_side_t                 side,
  output logic                               v,
  output logic [FRAC_BITS:0]                 quo [trs_pkg::ROT_N],
  output logic [trs_pkg::ROT_N-1:0]          quo_neg,
  output trs_pkg::trs_side_t                 quo_side
);

  localparam int QW = FRAC_BITS + 1;
  localparam int RW = trs_pkg::NORM_W;

  logic [RW-1:0]             rem    [QW][trs_pkg::ROT_N];
  logic [QW-1:0]             low    [QW][trs_pkg::ROT_N];
  logic [QW-1:0]             qbits  [QW][trs_pkg::ROT_N];
  logic [RW-1:0]             norm_s [QW];
  logic [trs_pkg::ROT_N-1:0] neg_s  [QW];
  trs_pkg::trs_side_t        side_s [QW];
  logic [QW-1:0]             v_s;

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW-1:0]             pn;
    logic [trs_pkg::ROT_N-1:0] pneg;
    trs_pkg::trs_side_t        pside;
    logic                      pv;

    if (s == 0) begin : g_head
      assign pn    = norm;
      assign pneg  = neg;
      assign pside = side;
      assign pv    = in_v;
    end else begin : g_body
      assign pn    = norm_s[s-1];
      assign pneg  = neg_s[s-1];
      assign pside = side_s[s-1];
      assign pv    = v_s[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[s] <= 1'b0;
      end else if (en) begin
        v_s[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        norm_s[s] <= pn;
        neg_s[s]  <= pneg;
        side_s[s] <= pside;
      end
    end

    for (genvar l = 0; l < trs_pkg::ROT_N; l++) begin : g_lane
      logic [RW-1:0] pr;
      logic [QW-1:0] pl, pq;
      logic [RW:0]   t, d;
      logic          ge;

      if (s == 0) begin : g_load
        assign pr = dvd[l][RW+QW-1:QW];
        assign pl = dvd[l][QW-1:0];
        assign pq = '0;
      end else begin : g_carry
        assign pr = rem[s-1][l];
        assign pl = low[s-1][l];
        assign pq = qbits[s-1][l];
      end

      assign t  = {pr, pl[QW-1]};
      assign d  = {1'b0, pn};
      assign ge = (t >= d);

      always_ff @(posedge clk) begin
        if (en) begin
          rem[s][l]   <= ge ? RW'(t - d) : RW'(t);
          low[s][l]   <= pl << 1;
          qbits[s][l] <= {pq[QW-2:0], ge};
        end
      end
    end
  end

  assign v        = v_s[QW-1];
  assign quo      = qbits[QW-1];
  assign quo_neg  = neg_s[QW-1];
  assign quo_side = side_s[QW-1];

endmodule

FILE: rtl/trs_compose.sv
// Rotation entries, scale and translation products, rounding and matrix assembly.
`timescale 1ns / 1ps
module trs_compose #(
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_v,
  input  logic [FRAC_BITS:0]                quo [trs_pkg::ROT_N],
  input  logic [trs_pkg::ROT_N-1:0]         quo_neg,
  input  trs_pkg::trs_side_t                quo_side,
  output logic                              v,
  output logic signed [trs_pkg::DATA_W-1:0] mat [4][4],
  output logic                              degen
);

  localparam int DW  = trs_pkg::DATA_W;
  localparam int AW  = trs_pkg::ACC_W;
  localparam int RW  = FRAC_BITS + 2;
  localparam int PW  = DW + RW;
  localparam int SW  = PW + 2;
  localparam int N   = trs_pkg::ROT_N;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] ONE   = DW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] SMAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN  = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] rs_sat(input logic signed [AW-1:0] val);
    logic [AW-1:0]          m;
    logic [AW-1:0]          r;
    logic signed [DW-1:0]   o;
    m = val[AW-1] ? AW'(-val) : AW'(val);
    r = (m + HALF) >> FRAC_BITS;
    if (val[AW-1]) begin
      if (r > AW'(SMAX)) begin
        o = SMIN;
      end else begin
        o = -$signed(r[DW-1:0]);
      end
    end else if (r > AW'(SMAX)) begin
      o = SMAX;
    end else begin
      o = $signed(r[DW-1:0]);
    end
    return o;
  endfunction

  logic [5:0]             vs;
  trs_pkg::trs_side_t     sd [5];
  logic signed [RW-1:0]   rot [N];
  logic signed [PW-1:0]   sc_prod [N];
  logic signed [PW-1:0]   dt_prod [N];
  logic signed [DW-1:0]   scl3 [N];
  logic signed [DW-1:0]   scl4 [N];
  logic signed [DW-1:0]   scl5 [N];
  logic signed [SW-1:0]   dsum [3];
  logic signed [DW-1:0]   p3 [3];
  logic signed [2*DW-1:0] m3 [3];
  logic signed [DW-1:0]   sc [3];
  logic signed [DW-1:0]   mv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= quo_side;
      sd[1] <= sd[0];
      sd[2] <= sd[1];
      sd[3] <= sd[2];
      sd[4] <= sd[3];
    end
  end

  assign sc[0] = sd[0].scale_x;
  assign sc[1] = sd[0].scale_y;
  assign sc[2] = sd[0].scale_z;
  assign mv[0] = sd[0].move_x;
  assign mv[1] = sd[0].move_y;
  assign mv[2] = sd[0].move_z;

  for (genvar e = 0; e < N; e++) begin : g_ent
    localparam int I = e / 3;
    localparam int J = e % 3;
    logic signed [RW-1:0] qs;
    logic signed [DW-1:0] fac;
    assign qs  = quo_neg[e] ? -$signed(RW'(quo[e])) : $signed(RW'(quo[e]));
    assign fac = sd[0].op ? sc[I] : sc[J];

    always_ff @(posedge clk) begin
      if (en) begin
        if (quo_side.degen) begin
          rot[e] <= (I == J) ? ONE_R : '0;
        end else begin
          rot[e] <= qs;
        end
        sc_prod[e] <= rot[e] * fac;
        dt_prod[e] <= rot[e] * mv[I];
        scl3[e]    <= rs_sat(AW'(sc_prod[e]));
        scl4[e]    <= scl3[e];
        scl5[e]    <= scl4[e];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_col
    logic signed [DW-1:0] s_j;
    logic signed [DW-1:0] t_j;
    assign s_j = (j == 0) ? sd[3].scale_x : (j == 1) ? sd[3].scale_y : sd[3].scale_z;
    assign t_j = (j == 0) ? sd[4].move_x : (j == 1) ? sd[4].move_y : sd[4].move_z;

    always_ff @(posedge clk) begin
      if (en) begin
        dsum[j]   <= SW'(dt_prod[j]) + SW'(dt_prod[3+j]) + SW'(dt_prod[6+j]);
        p3[j]     <= rs_sat(AW'(dsum[j]));
        m3[j]     <= p3[j] * s_j;
        mat[0][j] <= scl5[j];
        mat[1][j] <= scl5[3+j];
        mat[2][j] <= scl5[6+j];
        mat[3][j] <= sd[4].op ? t_j : rs_sat(AW'(m3[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat[0][3] <= '0;
      mat[1][3] <= '0;
      mat[2][3] <= '0;
      mat[3][3] <= ONE;
      degen     <= sd[4].degen;
    end
  end

  assign v = vs[5];

endmodule

FILE: rtl/trs_row_out.sv
// Holds a finished matrix and sends it one row per item.
`timescale 1ns / 1ps
module trs_row_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tail_v,
  input  logic signed [trs_pkg::DATA_W-1:0] mat [4][4],
  input  logic                              degen,
  output logic                              load,
  output logic                              valid,
  input  logic                              ready,
  output trs_pkg::trs_out_t                 data
);

  logic signed [trs_pkg::DATA_W-1:0] hold [4][4];
  logic                              hold_degen;
  logic [1:0]                        cnt;
  logic                              busy;

  assign load = tail_v && (!busy || (ready && cnt == 2'd3));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (busy && ready) begin
      if (cnt == 2'd3) begin
        busy <= 1'b0;
        cnt  <= 2'd0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold       <= mat;
      hold_degen <= degen;
    end
  end

  assign valid           = busy;
  assign data.row_index  = cnt;
  assign data.elem_c0    = hold[cnt][0];
  assign data.elem_c1    = hold[cnt][1];
  assign data.elem_c2    = hold[cnt][2];
  assign data.elem_c3    = hold[cnt][3];
  assign data.final_row  = (cnt == 2'd3);
  assign data.degenerate = hold_degen;

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst) !busy |-> cnt == 2'd0)
    else $error("row counter nonzero while idle");
  a_step: assert property (@(posedge clk) disable iff (rst)
    busy && ready && cnt != 2'd3 |=> busy && cnt == $past(cnt) + 2'd1)
    else $error("row counter did not advance");
  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && cnt == 2'd0)
    else $error("matrix load did not restart at row zero");

endmodule

FILE: rtl/trs_transform_matrix_builder.sv
// Top level of the quaternion translate/rotate/scale matrix builder.
//
// Input channel xform (valid/ready) takes one item: op, translation, scale and a
// quaternion, all signed Q16.16 at the default fraction width. Output channel row
// (valid/ready) returns four items per input, rows 0 to 3 in order, the last one
// marked by final_row; degenerate is set on all four when the quaternion is zero.
// The datapath is one pipeline under a common enable: three stages form products,
// norm and dividends, FRAC_BITS+1 stages divide one quotient bit each, six stages
// scale, round and assemble. Items enter every cycle until the pipeline fills; the
// row sender takes a new matrix only once the last row of the one before is taken.
// Ready drops while a finished matrix waits behind the one being sent; the whole
// pipeline then holds, nothing is lost or repeated. A low row_ready alone stalls
// only the row sender. Synchronous reset empties every stage and the sender.
`timescale 1ns / 1ps
module trs_transform_matrix_builder #(
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              xform_valid,
  output logic              xform_ready,
  input  trs_pkg::trs_in_t  xform,
  output logic              row_valid,
  input  logic              row_ready,
  output trs_pkg::trs_out_t row
);

  logic                               en;
  logic                               load;
  logic                               f_v, d_v, c_v;
  logic [trs_pkg::NORM_W+FRAC_BITS:0] dvd [trs_pkg::ROT_N];
  logic [trs_pkg::ROT_N-1:0]          f_neg, d_neg;
  logic [trs_pkg::NORM_W-1:0]         f_norm;
  trs_pkg::trs_side_t                 f_side, d_side;
  logic [FRAC_BITS:0]                 quo [trs_pkg::ROT_N];
  logic signed [trs_pkg::DATA_W-1:0]  mat [4][4];
  logic                               c_degen;

  assign en          = !c_v || load;
  assign xform_ready = en;

  trs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .in_v (xform_valid),
    .item (xform),
    .v    (f_v),
    .dvd  (dvd),
    .neg  (f_neg),
    .norm (f_norm),
    .side (f_side)
  );

  trs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (f_v),
    .dvd      (dvd),
    .neg      (f_neg),
    .norm     (f_norm),
    .side     (f_side),
    .v        (d_v),
    .quo      (quo),
    .quo_neg  (d_neg),
    .quo_side (d_side)
  );

  trs_compose #(.FRAC_BITS(FRAC_BITS)) u_compose (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (d_v),
    .quo      (quo),
    .quo_neg  (d_neg),
    .quo_side (d_side),
    .v        (c_v),
    .mat      (mat),
    .degen    (c_degen)
  );

  trs_row_out u_row_out (
    .clk    (clk),
    .rst    (rst),
    .tail_v (c_v),
    .mat    (mat),
    .degen  (c_degen),
    .load   (load),
    .valid  (row_valid),
    .ready  (row_ready),
    .data   (row)
  );

endmodule
